>>> rtl/lslf_pkg.sv
// lslf_pkg: widths, operation codes and control/status structs for the line fit
// shared by the controller, the datapath and the top level; no dependencies
`default_nettype none
package lslf_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int SUM_W      = 34;
   localparam int SQ_W       = 58;
   localparam int WIDE_W     = 200;
   localparam int MB_W       = 72;
   localparam int DIV_W      = 128;
   localparam int DEN_W      = 72;
   localparam int FIT_W      = 64;
   localparam int CORR_W     = 32;
   localparam int SRCH_W     = 31;
   localparam int ODD2_W     = 62;
   localparam int SEL_W      = 4;
   localparam int FRAC_SHIFT = 32;
   localparam int LIM_SHIFT  = 62;

   localparam logic [CORR_W-1:0] ONE_Q30 = 32'h4000_0000;

   // multiply operations, in the order the controller steps through them
   localparam logic [SEL_W-1:0] MUL_NXX  = 4'd0;
   localparam logic [SEL_W-1:0] MUL_XX   = 4'd1;
   localparam logic [SEL_W-1:0] MUL_NYY  = 4'd2;
   localparam logic [SEL_W-1:0] MUL_YY   = 4'd3;
   localparam logic [SEL_W-1:0] MUL_NXY  = 4'd4;
   localparam logic [SEL_W-1:0] MUL_XY   = 4'd5;
   localparam logic [SEL_W-1:0] MUL_YXX  = 4'd6;
   localparam logic [SEL_W-1:0] MUL_XXY  = 4'd7;
   localparam logic [SEL_W-1:0] MUL_PROD = 4'd8;
   localparam logic [SEL_W-1:0] MUL_MAG  = 4'd9;
   localparam logic [SEL_W-1:0] MUL_ODD  = 4'd10;

   localparam logic DIV_SLOPE = 1'b0;
   localparam logic DIV_ICPT  = 1'b1;

   typedef struct packed {
      logic             acc_en;
      logic             acc_clr;
      logic             mul_start;
      logic [SEL_W-1:0] mul_sel;
      logic             div_start;
      logic             div_sel;
      logic             srch_init;
      logic             odd_load;
      logic             out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic mul_done;
      logic div_done;
      logic dxx_nonpos;
      logic dyy_nonpos;
      logic srch_done;
   } dp_sts_type;

endpackage
`default_nettype wire

>>> rtl/least_squares_line_fit.sv
// least_squares_line_fit: points are summed one per cycle unless req_stall is high;
// a flagged point starts the fit: up to ten shift-add multiplies, two divides and
// a 31-round search for the correlation, each round one multiply
// the result waits in an output register while the next set accumulates
// synchronous reset clears the sums, the sequencer and the result valid; no clearing pass
`default_nettype none
module least_squares_line_fit #(
   parameter int MAX_POINTS = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [lslf_pkg::SAMPLE_W-1:0]  req_x_sample,
   input  wire logic signed [lslf_pkg::SAMPLE_W-1:0]  req_y_sample,
   input  wire logic                                  req_last_point,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [lslf_pkg::FIT_W-1:0]          rsp_fit_slope,
   output logic signed [lslf_pkg::FIT_W-1:0]          rsp_fit_intercept,
   output logic signed [lslf_pkg::CORR_W-1:0]         rsp_fit_correlation,
   output logic                                       rsp_fit_status
);

   lslf_pkg::dp_cmd_type cmd;
   lslf_pkg::dp_sts_type sts;

   lslf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_point (req_last_point),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .sts            (sts)
   );

   lslf_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_x_sample        (req_x_sample),
      .req_y_sample        (req_y_sample),
      .rsp_fit_slope       (rsp_fit_slope),
      .rsp_fit_intercept   (rsp_fit_intercept),
      .rsp_fit_correlation (rsp_fit_correlation),
      .rsp_fit_status      (rsp_fit_status)
   );

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_point) |=> req_stall)
      else $error("flagged transfer did not start the fit");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result overwritten before transfer");

   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !sts.mul_busy)
      else $error("multiply started while busy");

endmodule
`default_nettype wire

>>> rtl/lslf_mul.sv
// lslf_mul: shift-and-add multiplier, one multiplier bit per cycle
// uses lslf_pkg widths
`default_nettype none
module lslf_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lslf_pkg::WIDE_W-1:0]   op_a,
   input  wire logic [lslf_pkg::MB_W-1:0]     op_b,
   output logic [lslf_pkg::WIDE_W-1:0]        product,
   output logic                               busy,
   output logic                               done
);

   logic                          run_ff;
   logic [lslf_pkg::WIDE_W-1:0]   mcand_ff;
   logic [lslf_pkg::WIDE_W-1:0]   acc_ff;
   logic [lslf_pkg::MB_W-1:0]     mplier_ff;
   logic                          b_neg;
   logic [lslf_pkg::MB_W-1:0]     b_mag;

   assign b_neg   = op_b[lslf_pkg::MB_W-1];
   assign b_mag   = b_neg ? (~op_b + 1'b1) : op_b;
   assign done    = run_ff && (mplier_ff == '0);
   assign busy    = run_ff;
   assign product = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (done) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= b_neg ? (~op_a + 1'b1) : op_a;
         mplier_ff <= b_mag;
      end else if (run_ff && (mplier_ff != '0)) begin
         acc_ff    <= mplier_ff[0] ? (acc_ff + mcand_ff) : acc_ff;
         mcand_ff  <= {mcand_ff[lslf_pkg::WIDE_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[lslf_pkg::MB_W-1:1]};
      end
   end

endmodule
`default_nettype wire

>>> rtl/lslf_div.sv
// lslf_div: restoring unsigned divider, one quotient bit per cycle
// uses lslf_pkg widths
`default_nettype none
module lslf_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lslf_pkg::DIV_W-1:0]  dividend,
   input  wire logic [lslf_pkg::DEN_W-1:0]  divisor,
   output logic [lslf_pkg::DIV_W-1:0]       quotient,
   output logic                             done
);

   localparam int CNT_W = $clog2(lslf_pkg::DIV_W + 1);

   logic                         run_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [lslf_pkg::DIV_W-1:0]   nq_ff;
   logic [lslf_pkg::DEN_W-1:0]   rem_ff;
   logic [lslf_pkg::DEN_W-1:0]   dvs_ff;
   logic [lslf_pkg::DEN_W:0]     rem_shift;
   logic [lslf_pkg::DEN_W:0]     rem_diff;
   logic                         ge;

   assign rem_shift = {rem_ff, nq_ff[lslf_pkg::DIV_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign ge        = rem_shift >= {1'b0, dvs_ff};
   assign done      = run_ff && (cnt_ff == '0);
   assign quotient  = nq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (start) begin
         run_ff <= 1'b1;
      end else if (done) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= CNT_W'(lslf_pkg::DIV_W);
         nq_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (run_ff && (cnt_ff != '0)) begin
         cnt_ff <= cnt_ff - 1'b1;
         nq_ff  <= {nq_ff[lslf_pkg::DIV_W-2:0], ge};
         rem_ff <= ge ? rem_diff[lslf_pkg::DEN_W-1:0] : rem_shift[lslf_pkg::DEN_W-1:0];
      end
   end

endmodule
`default_nettype wire

>>> rtl/lslf_dp.sv
// lslf_dp: running sums, centered sums, divide and correlation search datapath
// uses lslf_pkg, lslf_mul and lslf_div
`default_nettype none
module lslf_dp #(
   parameter int MAX_POINTS = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire lslf_pkg::dp_cmd_type                  cmd,
   output lslf_pkg::dp_sts_type                       sts,
   input  wire logic signed [lslf_pkg::SAMPLE_W-1:0]  req_x_sample,
   input  wire logic signed [lslf_pkg::SAMPLE_W-1:0]  req_y_sample,
   output logic signed [lslf_pkg::FIT_W-1:0]          rsp_fit_slope,
   output logic signed [lslf_pkg::FIT_W-1:0]          rsp_fit_intercept,
   output logic signed [lslf_pkg::CORR_W-1:0]         rsp_fit_correlation,
   output logic                                       rsp_fit_status
);

   localparam int W     = lslf_pkg::WIDE_W;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
   localparam logic [lslf_pkg::FIT_W-1:0] SAT_MAX = {1'b0, {(lslf_pkg::FIT_W-1){1'b1}}};
   localparam logic [lslf_pkg::FIT_W-1:0] SAT_MIN = {1'b1, {(lslf_pkg::FIT_W-1){1'b0}}};

   logic [CNT_W-1:0]               cnt_ff;
   logic [lslf_pkg::SUM_W-1:0]     sx_ff, sy_ff;
   logic [lslf_pkg::SQ_W-1:0]      sxx_ff, syy_ff, sxy_ff;
   logic signed [2*lslf_pkg::SAMPLE_W-1:0] pxx, pyy, pxy;

   logic [W-1:0] dxx_ff, dyy_ff, dxy_ff, inum_ff, prod_ff, lim_ff;
   logic [lslf_pkg::SEL_W-1:0]     sel_ff;
   logic [W-1:0]                   mul_a;
   logic [lslf_pkg::MB_W-1:0]      mul_b;
   logic [W-1:0]                   mul_p;
   logic                           mul_busy, mul_done;

   logic [W-1:0]                   w_n, w_sx, w_sy, w_sxx, w_syy, w_sxy;
   logic [lslf_pkg::MB_W-1:0]      b_n, b_sx, b_sy;

   logic [lslf_pkg::SRCH_W-1:0]    lo_ff, hi_ff, mid_ff;
   logic [lslf_pkg::SRCH_W:0]      mid_sum;
   logic [lslf_pkg::SRCH_W-1:0]    mid, odd;
   logic [lslf_pkg::ODD2_W-1:0]    odd2_ff;

   logic [W-1:0]                   dsrc, dmag;
   logic                           dneg_ff, dsel_ff;
   logic [lslf_pkg::DIV_W-1:0]     dividend, quot;
   logic [lslf_pkg::DEN_W-1:0]     divisor;
   logic                           div_done;
   logic                           q_big_pos, q_big_neg;
   logic [lslf_pkg::FIT_W-1:0]     q_sat;
   logic [lslf_pkg::FIT_W-1:0]     slope_ff, icpt_ff;
   logic [lslf_pkg::CORR_W-1:0]    corr_mag, corr_val;

   logic [lslf_pkg::FIT_W-1:0]     out_slope_ff, out_icpt_ff;
   logic [lslf_pkg::CORR_W-1:0]    out_corr_ff;
   logic                           out_stat_ff;

   assign pxx = req_x_sample * req_x_sample;
   assign pyy = req_y_sample * req_y_sample;
   assign pxy = req_x_sample * req_y_sample;

   // running sums, points past the limit are dropped
   always_ff @(posedge clock) begin
      if (reset || cmd.acc_clr) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxx_ff <= '0;
         syy_ff <= '0;
         sxy_ff <= '0;
      end else if (cmd.acc_en && (cnt_ff < CNT_MAX)) begin
         cnt_ff <= cnt_ff + 1'b1;
         sx_ff  <= sx_ff + lslf_pkg::SUM_W'(req_x_sample);
         sy_ff  <= sy_ff + lslf_pkg::SUM_W'(req_y_sample);
         sxx_ff <= sxx_ff + lslf_pkg::SQ_W'(pxx);
         syy_ff <= syy_ff + lslf_pkg::SQ_W'(pyy);
         sxy_ff <= sxy_ff + lslf_pkg::SQ_W'(pxy);
      end
   end

   assign w_n   = W'(cnt_ff);
   assign w_sx  = W'($signed(sx_ff));
   assign w_sy  = W'($signed(sy_ff));
   assign w_sxx = W'($signed(sxx_ff));
   assign w_syy = W'($signed(syy_ff));
   assign w_sxy = W'($signed(sxy_ff));
   assign b_n   = lslf_pkg::MB_W'(cnt_ff);
   assign b_sx  = lslf_pkg::MB_W'($signed(sx_ff));
   assign b_sy  = lslf_pkg::MB_W'($signed(sy_ff));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_sel)
         lslf_pkg::MUL_NXX:  begin mul_a = w_sxx;   mul_b = b_n; end
         lslf_pkg::MUL_XX:   begin mul_a = w_sx;    mul_b = b_sx; end
         lslf_pkg::MUL_NYY:  begin mul_a = w_syy;   mul_b = b_n; end
         lslf_pkg::MUL_YY:   begin mul_a = w_sy;    mul_b = b_sy; end
         lslf_pkg::MUL_NXY:  begin mul_a = w_sxy;   mul_b = b_n; end
         lslf_pkg::MUL_XY:   begin mul_a = w_sy;    mul_b = b_sx; end
         lslf_pkg::MUL_YXX:  begin mul_a = w_sxx;   mul_b = b_sy; end
         lslf_pkg::MUL_XXY:  begin mul_a = w_sxy;   mul_b = b_sx; end
         lslf_pkg::MUL_PROD: begin mul_a = dxx_ff;  mul_b = dyy_ff[lslf_pkg::MB_W-1:0]; end
         lslf_pkg::MUL_MAG:  begin mul_a = dxy_ff;  mul_b = dxy_ff[lslf_pkg::MB_W-1:0]; end
         lslf_pkg::MUL_ODD:  begin
            mul_a = prod_ff;
            mul_b = lslf_pkg::MB_W'(odd2_ff);
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   lslf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p),
      .busy    (mul_busy),
      .done    (mul_done)
   );

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + 1'b1;
   assign mid     = mid_sum[lslf_pkg::SRCH_W:1];
   assign odd     = {mid[lslf_pkg::SRCH_W-2:0], 1'b0} - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         sel_ff <= cmd.mul_sel;
      end
      if (cmd.srch_init) begin
         lo_ff <= '0;
         hi_ff <= lslf_pkg::ONE_Q30[lslf_pkg::SRCH_W-1:0];
      end
      if (cmd.odd_load) begin
         mid_ff  <= mid;
         odd2_ff <= lslf_pkg::ODD2_W'(odd) * lslf_pkg::ODD2_W'(odd);
      end
      if (mul_done) begin
         unique case (sel_ff)
            lslf_pkg::MUL_NXX:  dxx_ff  <= mul_p;
            lslf_pkg::MUL_XX:   dxx_ff  <= dxx_ff - mul_p;
            lslf_pkg::MUL_NYY:  dyy_ff  <= mul_p;
            lslf_pkg::MUL_YY:   dyy_ff  <= dyy_ff - mul_p;
            lslf_pkg::MUL_NXY:  dxy_ff  <= mul_p;
            lslf_pkg::MUL_XY:   dxy_ff  <= dxy_ff - mul_p;
            lslf_pkg::MUL_YXX:  inum_ff <= mul_p;
            lslf_pkg::MUL_XXY:  inum_ff <= inum_ff - mul_p;
            lslf_pkg::MUL_PROD: prod_ff <= mul_p;
            lslf_pkg::MUL_MAG:  lim_ff  <= mul_p << lslf_pkg::LIM_SHIFT;
            lslf_pkg::MUL_ODD: begin
               if (mul_p <= lim_ff) begin
                  lo_ff <= mid_ff;
               end else begin
                  hi_ff <= mid_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // rounded quotient: (2|num| + den) / (2 den)
   assign dsrc     = (cmd.div_sel == lslf_pkg::DIV_ICPT) ? inum_ff : dxy_ff;
   assign dmag     = dsrc[W-1] ? (~dsrc + 1'b1) : dsrc;
   assign dividend = lslf_pkg::DIV_W'(dmag << (lslf_pkg::FRAC_SHIFT + 1))
                     + dxx_ff[lslf_pkg::DIV_W-1:0];
   assign divisor  = {dxx_ff[lslf_pkg::DEN_W-2:0], 1'b0};

   lslf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quot),
      .done     (div_done)
   );

   assign q_big_pos = (quot[lslf_pkg::DIV_W-1:lslf_pkg::FIT_W-1] != '0);
   assign q_big_neg = (quot[lslf_pkg::DIV_W-1:lslf_pkg::FIT_W] != '0)
                      || (quot[lslf_pkg::FIT_W-1] && (quot[lslf_pkg::FIT_W-2:0] != '0));

   always_comb begin
      if (!dneg_ff) begin
         q_sat = q_big_pos ? SAT_MAX : quot[lslf_pkg::FIT_W-1:0];
      end else begin
         q_sat = q_big_neg ? SAT_MIN : (~quot[lslf_pkg::FIT_W-1:0] + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dneg_ff <= dsrc[W-1];
         dsel_ff <= cmd.div_sel;
      end
      if (div_done) begin
         if (dsel_ff == lslf_pkg::DIV_ICPT) begin
            icpt_ff <= q_sat;
         end else begin
            slope_ff <= q_sat;
         end
      end
   end

   assign sts.mul_busy   = mul_busy;
   assign sts.mul_done   = mul_done;
   assign sts.div_done   = div_done;
   assign sts.dxx_nonpos = dxx_ff[W-1] || (dxx_ff == '0);
   assign sts.dyy_nonpos = dyy_ff[W-1] || (dyy_ff == '0);
   assign sts.srch_done  = (lo_ff >= hi_ff);

   assign corr_mag = lslf_pkg::CORR_W'(lo_ff);
   assign corr_val = sts.dyy_nonpos ? lslf_pkg::ONE_Q30
                   : (dxy_ff[W-1] ? (~corr_mag + 1'b1) : corr_mag);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (sts.dxx_nonpos) begin
            out_slope_ff <= '0;
            out_icpt_ff  <= '0;
            out_corr_ff  <= '0;
            out_stat_ff  <= 1'b1;
         end else begin
            out_slope_ff <= slope_ff;
            out_icpt_ff  <= icpt_ff;
            out_corr_ff  <= corr_val;
            out_stat_ff  <= 1'b0;
         end
      end
   end

   assign rsp_fit_slope       = out_slope_ff;
   assign rsp_fit_intercept   = out_icpt_ff;
   assign rsp_fit_correlation = out_corr_ff;
   assign rsp_fit_status      = out_stat_ff;

endmodule
`default_nettype wire

>>> rtl/lslf_ctrl.sv
// lslf_ctrl: state machine that sequences accumulation, multiplies, divides and search
// uses lslf_pkg command and status structs
`default_nettype none
module lslf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_last_point,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lslf_pkg::dp_cmd_type        cmd,
   input  wire lslf_pkg::dp_sts_type   sts
);

   localparam logic [3:0] S_ACC   = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_MWAIT = 4'd2;
   localparam logic [3:0] S_CHKX  = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_DWAIT = 4'd5;
   localparam logic [3:0] S_CHKY  = 4'd6;
   localparam logic [3:0] S_SINIT = 4'd7;
   localparam logic [3:0] S_SODD  = 4'd8;
   localparam logic [3:0] S_SMUL  = 4'd9;
   localparam logic [3:0] S_SWAIT = 4'd10;
   localparam logic [3:0] S_FIN   = 4'd11;

   logic [3:0]                   state_ff, state_in;
   logic [lslf_pkg::SEL_W-1:0]   step_ff, step_in;
   logic                         dsel_ff, dsel_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept;
   logic                         out_free;

   assign req_stall = (state_ff != S_ACC);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dsel_in  = dsel_ff;
      cmd      = '0;
      cmd.mul_sel = step_ff;
      cmd.div_sel = dsel_ff;
      unique case (state_ff)
         S_ACC: begin
            cmd.acc_en = accept;
            if (accept && req_last_point) begin
               step_in  = lslf_pkg::MUL_NXX;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_start = 1'b1;
            state_in      = S_MWAIT;
         end
         S_MWAIT: begin
            if (sts.mul_done) begin
               if (step_ff == lslf_pkg::MUL_XY) begin
                  state_in = S_CHKX;
               end else if (step_ff == lslf_pkg::MUL_XXY) begin
                  dsel_in  = lslf_pkg::DIV_SLOPE;
                  state_in = S_DIV;
               end else if (step_ff == lslf_pkg::MUL_MAG) begin
                  state_in = S_SINIT;
               end else begin
                  // codes run in sequence order
                  step_in  = step_ff + 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_CHKX: begin
            if (sts.dxx_nonpos) begin
               state_in = S_FIN;
            end else begin
               step_in  = lslf_pkg::MUL_YXX;
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (sts.div_done) begin
               if (dsel_ff == lslf_pkg::DIV_SLOPE) begin
                  dsel_in  = lslf_pkg::DIV_ICPT;
                  state_in = S_DIV;
               end else begin
                  state_in = S_CHKY;
               end
            end
         end
         S_CHKY: begin
            if (sts.dyy_nonpos) begin
               state_in = S_FIN;
            end else begin
               step_in  = lslf_pkg::MUL_PROD;
               state_in = S_MUL;
            end
         end
         S_SINIT: begin
            cmd.srch_init = 1'b1;
            state_in      = S_SODD;
         end
         S_SODD: begin
            if (sts.srch_done) begin
               state_in = S_FIN;
            end else begin
               cmd.odd_load = 1'b1;
               state_in     = S_SMUL;
            end
         end
         S_SMUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = lslf_pkg::MUL_ODD;
            state_in      = S_SWAIT;
         end
         S_SWAIT: begin
            if (sts.mul_done) begin
               state_in = S_SODD;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.acc_clr  = 1'b1;
               state_in     = S_ACC;
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACC;
         step_ff      <= lslf_pkg::MUL_NXX;
         dsel_ff      <= lslf_pkg::DIV_SLOPE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         dsel_ff      <= dsel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

>>> dv/tb.sv
// tb: self-checking testbench for least_squares_line_fit, predicts each fit from
// exact running sums and compares every result transfer; depends on rtl/lslf_pkg.sv and the rtl design
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  MAX_PTS   = 1024;
   localparam int  FIT_LAT   = 3000;
   localparam longint LIMIT  = 20_000_000;
   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;
   localparam logic FIT_OK      = 1'b0;
   localparam logic FIT_NO_XVAR = 1'b1;

   typedef struct {
      logic [lslf_pkg::FIT_W-1:0]  slope;
      logic [lslf_pkg::FIT_W-1:0]  icpt;
      logic [lslf_pkg::CORR_W-1:0] corr;
      logic                        status;
   } fit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [lslf_pkg::SAMPLE_W-1:0] req_x_sample = '0;
   logic signed [lslf_pkg::SAMPLE_W-1:0] req_y_sample = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [lslf_pkg::FIT_W-1:0]  rsp_fit_slope;
   logic signed [lslf_pkg::FIT_W-1:0]  rsp_fit_intercept;
   logic signed [lslf_pkg::CORR_W-1:0] rsp_fit_correlation;
   logic rsp_fit_status;

   least_squares_line_fit u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   fit_type fit_q[$];
   int      errors = 0;
   int      sent = 0;
   longint  cycles = 0;
   bit      tx_idle = 1'b1;
   bit      rx_idle = 1'b1;
   int      hold_cycles = 0;

   // running sums of the set in progress
   int     n_pts;
   longint s_x, s_y, s_xx, s_yy, s_xy;

   function automatic logic [63:0] round_q32(input logic signed [255:0] num,
                                              input logic signed [255:0] den);
      logic [255:0] mag, d, q;
      logic neg;
      neg = num < 0;
      mag = neg ? -num : num;
      d = den;
      q = (mag * 2 + d) / (d * 2);
      if (!neg) return (q > POS_MAX) ? POS_MAX : q[63:0];
      return (q > NEG_MIN) ? NEG_MIN : -q[63:0];
   endfunction

   function automatic fit_type fit_sums();
      fit_type r;
      logic signed [255:0] wn, sx, sy, dxx, dyy, dxy, inum;
      logic [255:0] mag, prod, lim;
      longint unsigned lo, hi, mid, odd;
      wn = n_pts; sx = s_x; sy = s_y;
      dxx = wn * s_xx - sx * sx;
      dyy = wn * s_yy - sy * sy;
      dxy = wn * s_xy - sx * sy;
      r = '{slope: '0, icpt: '0, corr: '0, status: FIT_OK};
      if (dxx <= 0) begin
         r.status = FIT_NO_XVAR;
         return r;
      end
      inum = sy * s_xx - sx * s_xy;
      r.slope = round_q32(dxy <<< lslf_pkg::FRAC_SHIFT, dxx);
      r.icpt  = round_q32(inum <<< lslf_pkg::FRAC_SHIFT, dxx);
      if (dyy <= 0) begin
         r.corr = lslf_pkg::ONE_Q30;
         return r;
      end
      mag  = (dxy < 0) ? -dxy : dxy;
      prod = dxx * dyy;
      lim  = (mag * mag) << lslf_pkg::LIM_SHIFT;
      lo = 0;
      hi = lslf_pkg::ONE_Q30;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         odd = 2 * mid - 1;
         if ({192'b0, odd * odd} * prod <= lim) lo = mid;
         else hi = mid - 1;
      end
      r.corr = (dxy < 0) ? -lo[31:0] : lo[31:0];
      return r;
   endfunction

   function automatic void add_point(input longint x, input longint y, input bit last);
      if (n_pts < MAX_PTS) begin
         n_pts++;
         s_x += x; s_y += y;
         s_xx += x * x; s_yy += y * y; s_xy += x * y;
      end
      if (last) begin
         fit_q.insert(fit_q.size(), fit_sums());
         n_pts = 0; s_x = 0; s_y = 0; s_xx = 0; s_yy = 0; s_xy = 0;
      end
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_point(input int x, input int y, input bit last);
      while (tx_idle && $urandom_range(99) < 22) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_x_sample = x[lslf_pkg::SAMPLE_W-1:0];
      req_y_sample = y[lslf_pkg::SAMPLE_W-1:0];
      req_last_point = last;
      do @(posedge clock); while (req_stall);
      add_point(longint'(req_x_sample), longint'(req_y_sample), last);
      sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (fit_q.size() != 0) @(negedge clock);
   endtask

   function automatic int rand_sample();
      return int'($urandom) >>> 8;
   endfunction

   task automatic test_directed();
      send_point(100, 5, 1'b1);
      send_point(7, 1, 1'b0); send_point(7, 9, 1'b1);
      send_point(1, 3, 1'b0); send_point(2, 3, 1'b0); send_point(5, 3, 1'b1);
      send_point(-8388608, 8388607, 1'b0); send_point(8388607, -8388608, 1'b1);
      send_point(0, 0, 1'b0); send_point(1, 2, 1'b0); send_point(2, 4, 1'b1);
      send_point(8388606, -8388608, 1'b0); send_point(8388607, 8388607, 1'b1);
      send_point(-8388608, -8388608, 1'b0); send_point(-8388607, 8388607, 1'b1);
      send_point(-3, 10, 1'b0); send_point(4, -11, 1'b0); send_point(9, 2, 1'b1);
      send_point(-8388608, -8388608, 1'b0); send_point(8388607, 8388607, 1'b0);
      send_point(-8388608, 8388607, 1'b0); send_point(8388607, -8388608, 1'b1);
   endtask

   // more than the point limit; extremes make the largest sums
   task automatic test_overflow();
      for (int i = 0; i < MAX_PTS + 6; i++)
         send_point((i % 2) ? 8388607 : -8388608, (i % 3) ? -8388608 : rand_sample(),
                    i == MAX_PTS + 5);
   endtask

   // receiver holds off while sets keep coming, so the block backs up
   task automatic test_backpressure();
      hold_cycles = 12000;
      for (int s = 0; s < 4; s++)
         for (int i = 0; i < 6; i++) send_point(rand_sample(), rand_sample(), i == 5);
      wait_drained();
   endtask

   task automatic random_sets(input int n_items);
      int size, mode, a, b, x, y;
      while (sent < n_items) begin
         mode = $urandom_range(3);
         size = ($urandom_range(99) < 5) ? $urandom_range(300, 40) : $urandom_range(12, 1);
         a = $urandom_range(200) - 100;
         b = $urandom_range(20000) - 10000;
         for (int i = 0; i < size; i++) begin
            case (mode)
               0: begin x = rand_sample(); y = rand_sample(); end
               1: begin x = $urandom_range(40) - 20; y = $urandom_range(40) - 20; end
               2: begin
                  x = $urandom_range(60000) - 30000;
                  y = a * x + b + $urandom_range(64) - 32;
               end
               default: begin x = rand_sample(); y = ($urandom_range(1)) ? b : rand_sample(); end
            endcase
            send_point(x, y, i == size - 1);
         end
      end
   endtask

   task automatic test_no_idle();
      tx_idle = 1'b0; rx_idle = 1'b0;
      random_sets(sent + 120);
      wait_drained();
      tx_idle = 1'b1; rx_idle = 1'b1;
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rx_idle && ($urandom_range(99) < 22);
      end
   end

   always @(posedge clock) begin
      fit_type e;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fit_q.size() == 0) begin
            $error("result transfer with no fit expected");
            errors++;
         end else begin
            e = fit_q.pop_front();
            if (rsp_fit_slope !== e.slope) begin
               $error("fit_slope exp %h got %h", e.slope, rsp_fit_slope); errors++;
            end
            if (rsp_fit_intercept !== e.icpt) begin
               $error("fit_intercept exp %h got %h", e.icpt, rsp_fit_intercept); errors++;
            end
            if (rsp_fit_correlation !== e.corr) begin
               $error("fit_correlation exp %h got %h", e.corr, rsp_fit_correlation); errors++;
            end
            if (rsp_fit_status !== e.status) begin
               $error("fit_status exp %b got %b", e.status, rsp_fit_status); errors++;
            end
         end
      end
   end

   initial begin
      n_pts = 0; s_x = 0; s_y = 0; s_xx = 0; s_yy = 0; s_xy = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      wait_drained();
      test_backpressure();
      test_overflow();
      test_no_idle();
      random_sets(sent + 60);
      wait_drained();
      repeat (FIT_LAT) @(posedge clock);
      if (errors == 0 && fit_q.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
